// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the inductor position ratio RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition is followed by another one in the next cycle.
`define ASSERT_NEXT(label, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== rtl/ipr_pkg.sv =====
// Package of the inductor position ratio block: widths, codes and types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ipr_pkg;

	localparam int CHANNELS            = 4;
	localparam int CHANNEL_BITS        = 2;
	localparam int SAMPLE_BITS         = 12;
	localparam int SAMPLES_PER_CHANNEL = 5;
	localparam int SUM_BITS            = 15;
	localparam int Q_BITS              = 15;
	localparam int Q_ONE               = 1 << Q_BITS;
	localparam int MIN_SUM_BITS        = 13;
	localparam int WEIGHT_BITS         = 16;
	localparam int POS_BITS            = 16;
	localparam int PATH_BITS           = 2;
	localparam int QUEUE_DEPTH         = 2;
	localparam int DIV_NUM_BITS        = SUM_BITS + Q_BITS;
	localparam int DIV_DEN_BITS        = SUM_BITS + 1;
	localparam int ADDR_BITS           = 3;
	localparam int DATA_BITS           = 32;

	localparam logic [MIN_SUM_BITS-1:0] MIN_SUM_RESET = MIN_SUM_BITS'(100);
	localparam logic [WEIGHT_BITS-1:0]  WEIGHT_RESET  = WEIGHT_BITS'(8192);

	localparam logic REG_MIN_SUM = 1'b0;
	localparam logic REG_WEIGHT  = 1'b1;

	localparam logic [PATH_BITS-1:0] PATH_NONE  = 2'd0;
	localparam logic [PATH_BITS-1:0] PATH_HORIZ = 2'd1;
	localparam logic [PATH_BITS-1:0] PATH_BLEND = 2'd2;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0]  sample;
		logic [CHANNEL_BITS-1:0] channel;
		logic                    frame_end;
	} item_t;

	typedef struct packed {
		logic signed [POS_BITS-1:0] position;
		logic [PATH_BITS-1:0]       path;
	} result_t;

	typedef struct packed {
		logic [CHANNELS-1:0][SUM_BITS-1:0] trim;
	} frame_t;

	typedef struct packed {
		logic [MIN_SUM_BITS-1:0] min_sum;
		logic [WEIGHT_BITS-1:0]  weight;
	} cfg_t;

	typedef struct packed {
		logic                    start;
		logic [DIV_NUM_BITS-1:0] num;
		logic [DIV_DEN_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic [DIV_NUM_BITS-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ipr_front.sv =====
// Front part: accepts samples and keeps each channel's sum, maximum and minimum.
// On a frame end it pushes the trimmed sums into the queue. Depends on ipr_pkg.
`default_nettype none

module ipr_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire ipr_pkg::item_t item,
	input  wire logic           full,
	output logic                push,
	output ipr_pkg::frame_t     frame
);

	localparam int CH = ipr_pkg::CHANNELS;
	localparam int SB = ipr_pkg::SAMPLE_BITS;
	localparam int MW = ipr_pkg::SUM_BITS;

	logic [CH-1:0][MW-1:0] sum_q, sum_d;
	logic [CH-1:0][SB-1:0] max_q, max_d;
	logic [CH-1:0][SB-1:0] min_q, min_d;
	logic                  accept;

	assign accept = start && !full;
	assign push   = accept && item.frame_end;

	always_comb begin
		logic [MW:0]   ext;
		logic [MW+1:0] diff;
		ext  = '0;
		diff = '0;
		for (int c = 0; c < CH; c++) begin
			sum_d[c] = sum_q[c];
			max_d[c] = max_q[c];
			min_d[c] = min_q[c];
			if (ipr_pkg::CHANNEL_BITS'(c) == item.channel) begin
				ext = {1'b0, sum_q[c]} + (MW+1)'(item.sample);
				sum_d[c] = ext[MW] ? '1 : ext[MW-1:0];
				if (item.sample > max_q[c]) begin
					max_d[c] = item.sample;
				end
				if (item.sample < min_q[c]) begin
					min_d[c] = item.sample;
				end
			end
			diff = (MW+2)'(sum_d[c]) - (MW+2)'(max_d[c]) - (MW+2)'(min_d[c]);
			frame.trim[c] = diff[MW+1] ? '0 : diff[MW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			max_q <= '0;
			min_q <= '1;
		end else if (accept) begin
			if (item.frame_end) begin
				sum_q <= '0;
				max_q <= '0;
				min_q <= '1;
			end else begin
				sum_q <= sum_d;
				max_q <= max_d;
				min_q <= min_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ipr_queue.sv =====
// Short queue of frames between the front and the back part.
// Register array read at the head pointer. Depends on ipr_pkg.
`default_nettype none

module ipr_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ipr_pkg::frame_t push_data,
	input  wire logic            pop,
	output ipr_pkg::frame_t      head,
	output logic                 full,
	output logic                 empty
);

	localparam int DEPTH = ipr_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	ipr_pkg::frame_t ent_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ipr_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Serves the horizontal and the vertical ratio. Depends on ipr_pkg.
`default_nettype none

module ipr_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ipr_pkg::div_req_t req,
	output ipr_pkg::div_rsp_t      rsp
);

	localparam int NW = ipr_pkg::DIV_NUM_BITS;
	localparam int DW = ipr_pkg::DIV_DEN_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	assign trial    = {rem_q, quo_q[NW-1]};
	assign diff     = trial - {1'b0, den_q};
	assign fits     = (trial >= {1'b0, den_q});
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (run_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ipr_back.sv =====
// Back part: sequencer that forms trimmed means, ratios and the blend for one frame.
// Uses the shared divider through request and response structs. Depends on ipr_pkg.
`default_nettype none
`include "assert_macros.svh"

module ipr_back #(
	parameter int SAMPLES_PER_CHANNEL = ipr_pkg::SAMPLES_PER_CHANNEL
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ipr_pkg::cfg_t     cfg,
	input  wire ipr_pkg::frame_t   head,
	input  wire logic              empty,
	output logic                   pop,
	output ipr_pkg::div_req_t      div_req,
	input  wire ipr_pkg::div_rsp_t div_rsp,
	output logic                   done,
	output ipr_pkg::result_t       result
);

	localparam int CH      = ipr_pkg::CHANNELS;
	localparam int MW      = ipr_pkg::SUM_BITS;
	localparam int QB      = ipr_pkg::Q_BITS;
	localparam int NW      = ipr_pkg::DIV_NUM_BITS;
	localparam int DW      = ipr_pkg::DIV_DEN_BITS;
	localparam int PB      = ipr_pkg::POS_BITS;
	localparam int RW      = QB + 2;
	localparam int PW      = 2 * RW;
	localparam int AW      = PW + 1;
	localparam int SW      = AW - QB;
	localparam int DIVISOR = SAMPLES_PER_CHANNEL - 2;
	localparam int MSH     = MW + $clog2(DIVISOR);
	localparam int PRW     = MSH + MW;
	localparam int RB      = MW + 2;

	// Each trimmed mean is the trimmed sum times the rounded-up reciprocal of the divisor.
	localparam logic [RB-1:0] RECIP = RB'(((1 << MSH) + DIVISOR - 1) / DIVISOR);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_MEAN_GO   = 4'd1;
	localparam logic [3:0] S_MEAN_WAIT = 4'd2;
	localparam logic [3:0] S_CHECK     = 4'd3;
	localparam logic [3:0] S_H_WAIT    = 4'd4;
	localparam logic [3:0] S_V_WAIT    = 4'd5;
	localparam logic [3:0] S_MUL1      = 4'd6;
	localparam logic [3:0] S_MUL2      = 4'd7;
	localparam logic [3:0] S_ADD       = 4'd8;
	localparam logic [3:0] S_FIN       = 4'd9;

	logic [3:0]            state_q, state_d;
	logic [1:0]            idx_q, idx_d;
	logic                  done_q, done_d;
	ipr_pkg::result_t      res_q, res_d;
	ipr_pkg::frame_t       t_q;
	logic [CH-1:0][MW-1:0] m_q;
	logic [PRW-1:0]        mprod_q;
	logic                  hneg_q, vneg_q, v_ok_q;
	logic [MW-1:0]         vmag_q;
	logic signed [RW-1:0]  h_q, v_q;
	logic signed [PW-1:0]  p1_q, p2_q;
	logic signed [AW-1:0]  acc_q;

	logic [MW:0]           hsum, vsum;
	logic signed [MW:0]    hdiff, vdiff;
	logic [MW-1:0]         hmag, vmag;
	logic                  h_ok, v_ok;
	logic [RW-1:0]         quo_ext;
	logic signed [RW-1:0]  quo_signed;
	logic [QB:0]           w_clamp;
	logic [QB:0]           w_rest;
	logic signed [AW-1:0]  acc_adj;
	logic signed [SW-1:0]  acc_shift;

	assign hsum  = {1'b0, m_q[1]} + {1'b0, m_q[2]};
	assign vsum  = {1'b0, m_q[0]} + {1'b0, m_q[3]};
	assign hdiff = $signed({1'b0, m_q[1]}) - $signed({1'b0, m_q[2]});
	assign vdiff = $signed({1'b0, m_q[0]}) - $signed({1'b0, m_q[3]});
	assign hmag  = hdiff[MW] ? MW'(-hdiff) : hdiff[MW-1:0];
	assign vmag  = vdiff[MW] ? MW'(-vdiff) : vdiff[MW-1:0];
	assign h_ok  = (hsum != '0) && (hsum >= (MW+1)'(cfg.min_sum));
	assign v_ok  = (vsum != '0) && (vsum >= (MW+1)'(cfg.min_sum));

	assign quo_ext = {1'b0, div_rsp.quo[QB:0]};
	always_comb begin
		if ((state_q == S_H_WAIT) ? hneg_q : vneg_q) begin
			quo_signed = -$signed(quo_ext);
		end else begin
			quo_signed = $signed(quo_ext);
		end
	end

	assign w_clamp   = (cfg.weight > (QB+1)'(ipr_pkg::Q_ONE)) ?
	                   (QB+1)'(ipr_pkg::Q_ONE) : cfg.weight[QB:0];
	assign w_rest    = (QB+1)'(ipr_pkg::Q_ONE) - w_clamp;
	assign acc_adj   = acc_q[AW-1] ? acc_q + $signed(AW'(ipr_pkg::Q_ONE - 1)) : acc_q;
	assign acc_shift = SW'(acc_adj >>> QB);

	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		done_d        = 1'b0;
		res_d         = res_q;
		pop           = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					idx_d   = '0;
					state_d = S_MEAN_GO;
				end
			end
			S_MEAN_GO: begin
				state_d = S_MEAN_WAIT;
			end
			S_MEAN_WAIT: begin
				idx_d   = idx_q + 1'b1;
				state_d = (idx_q == 2'd3) ? S_CHECK : S_MEAN_GO;
			end
			S_CHECK: begin
				div_req.num = NW'({hmag, QB'(0)});
				div_req.den = DW'(hsum);
				if (h_ok) begin
					div_req.start = 1'b1;
					state_d       = S_H_WAIT;
				end else begin
					done_d         = 1'b1;
					res_d.position = '0;
					res_d.path     = ipr_pkg::PATH_NONE;
					state_d        = S_IDLE;
				end
			end
			S_H_WAIT: begin
				div_req.num = NW'({vmag_q, QB'(0)});
				div_req.den = DW'(vsum);
				if (div_rsp.done) begin
					if (v_ok_q) begin
						div_req.start = 1'b1;
						state_d       = S_V_WAIT;
					end else begin
						done_d         = 1'b1;
						res_d.path     = ipr_pkg::PATH_HORIZ;
						res_d.position = (quo_signed > $signed(RW'(ipr_pkg::Q_ONE - 1))) ?
						                 PB'(ipr_pkg::Q_ONE - 1) : quo_signed[PB-1:0];
						state_d        = S_IDLE;
					end
				end
			end
			S_V_WAIT: begin
				if (div_rsp.done) begin
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				state_d = S_MUL2;
			end
			S_MUL2: begin
				state_d = S_ADD;
			end
			S_ADD: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				done_d     = 1'b1;
				res_d.path = ipr_pkg::PATH_BLEND;
				if (acc_shift > $signed(SW'(ipr_pkg::Q_ONE - 1))) begin
					res_d.position = PB'(ipr_pkg::Q_ONE - 1);
				end else if (acc_shift < -$signed(SW'(ipr_pkg::Q_ONE))) begin
					res_d.position = PB'(ipr_pkg::Q_ONE);
				end else begin
					res_d.position = acc_shift[PB-1:0];
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (pop) begin
			t_q <= head;
		end
		if (state_q == S_MEAN_GO) begin
			mprod_q <= PRW'(t_q.trim[idx_q]) * PRW'(RECIP);
		end
		if (state_q == S_MEAN_WAIT) begin
			m_q[idx_q] <= mprod_q[MSH +: MW];
		end
		if (state_q == S_CHECK) begin
			hneg_q <= hdiff[MW];
			vneg_q <= vdiff[MW];
			vmag_q <= vmag;
			v_ok_q <= v_ok;
		end
		if (state_q == S_H_WAIT && div_rsp.done) begin
			h_q <= quo_signed;
		end
		if (state_q == S_V_WAIT && div_rsp.done) begin
			v_q <= quo_signed;
		end
		if (state_q == S_MUL1) begin
			p1_q <= h_q * $signed({1'b0, w_rest});
		end
		if (state_q == S_MUL2) begin
			p2_q <= v_q * $signed({1'b0, w_clamp});
		end
		if (state_q == S_ADD) begin
			acc_q <= AW'(p1_q) + AW'(p2_q);
		end
	end

	assign done   = done_q;
	assign result = res_q;

	`ASSERT_ALWAYS(a_path_none_zero, done_q |-> (res_q.path != ipr_pkg::PATH_NONE || res_q.position == '0), "path none with nonzero position")
	`ASSERT_NEXT(a_div_not_instant, div_req.start, !div_rsp.done, "divider finished right after start")
	`ASSERT_ALWAYS(a_done_source, done_q |-> ($past(state_q) == S_CHECK || $past(state_q) == S_H_WAIT || $past(state_q) == S_FIN), "result from unexpected state")

endmodule

`default_nettype wire

// ===== rtl/inductor_position_ratio_top.sv =====
// Top level of the inductor position ratio block: configuration registers,
// front, queue, shared divider and back. Depends on ipr_pkg and all ipr_ modules.
//
//  Channel   Signals                    Transaction at rising edge
//  input     start, busy, item          start high and busy low
//  result    done, result               done high, one cycle, no stall
//  config    psel .. pwdata, prdata     psel, penable, pwrite, pready high
//
// Busy rises only while the two-entry frame queue is full. The back part
// pops a frame and, for a blended result, forms four channel means, runs
// two divisions in the shared divider, then multiply, add and saturate
// steps before it raises done; a pair below the threshold ends the frame
// early. Reset clears the channel accumulators at once and loads min_sum
// 100 and vertical_weight 8192.
`default_nettype none

module inductor_position_ratio_top #(
	parameter int SAMPLES_PER_CHANNEL = ipr_pkg::SAMPLES_PER_CHANNEL
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire ipr_pkg::item_t                  item,
	output logic                                 done,
	output ipr_pkg::result_t                     result,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ipr_pkg::ADDR_BITS-1:0]   paddr,
	input  wire logic [ipr_pkg::DATA_BITS-1:0]   pwdata,
	output logic [ipr_pkg::DATA_BITS-1:0]        prdata,
	output logic                                 pready
);

	ipr_pkg::cfg_t     cfg_q;
	ipr_pkg::frame_t   push_frame;
	ipr_pkg::frame_t   head;
	ipr_pkg::div_req_t div_req;
	ipr_pkg::div_rsp_t div_rsp;
	logic              push;
	logic              pop;
	logic              full;
	logic              empty;
	logic              reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign busy    = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_sum <= ipr_pkg::MIN_SUM_RESET;
			cfg_q.weight  <= ipr_pkg::WEIGHT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				ipr_pkg::REG_MIN_SUM: cfg_q.min_sum <= pwdata[ipr_pkg::MIN_SUM_BITS-1:0];
				ipr_pkg::REG_WEIGHT:  cfg_q.weight  <= pwdata[ipr_pkg::WEIGHT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			ipr_pkg::REG_MIN_SUM: prdata = ipr_pkg::DATA_BITS'(cfg_q.min_sum);
			ipr_pkg::REG_WEIGHT:  prdata = ipr_pkg::DATA_BITS'(cfg_q.weight);
			default:              prdata = '0;
		endcase
	end

	ipr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.full   (full),
		.push   (push),
		.frame  (push_frame)
	);

	ipr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_frame),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	ipr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	ipr_back #(
		.SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.div_req (div_req),
		.div_rsp (div_rsp),
		.done    (done),
		.result  (result)
	);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for inductor_position_ratio_top: frames of ADC samples
// are driven through the command port and each frame result is predicted and compared.
// Depends on ipr_pkg and the block's RTL; the scoreboard class holds the prediction.
`timescale 1ns / 1ps

module tb;
	import ipr_pkg::*;

	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 300;
	localparam int PHASE_ITEMS  = 115;

	localparam logic [ADDR_BITS-1:0] ADDR_MIN_SUM = {REG_MIN_SUM, 2'b00};
	localparam logic [ADDR_BITS-1:0] ADDR_WEIGHT  = {REG_WEIGHT, 2'b00};

	localparam int MODE_UNIFORM = 0;
	localparam int MODE_NEAR    = 1;
	localparam int MODE_EXTREME = 2;
	localparam int MODE_ZERO    = 3;

	class position_scoreboard;
		logic [SUM_BITS-1:0]     chan_sum [CHANNELS];
		logic [SAMPLE_BITS-1:0]  chan_max [CHANNELS];
		logic [SAMPLE_BITS-1:0]  chan_min [CHANNELS];
		logic [MIN_SUM_BITS-1:0] min_sum;
		logic [WEIGHT_BITS-1:0]  weight;
		result_t                 pending [$];
		int                      errors;

		function new();
			min_sum = MIN_SUM_RESET;
			weight  = WEIGHT_RESET;
			errors  = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			for (int c = 0; c < CHANNELS; c++) begin
				chan_sum[c] = '0;
				chan_max[c] = '0;
				chan_min[c] = '1;
			end
		endfunction

		function void set_register(logic [ADDR_BITS-1:0] addr, logic [DATA_BITS-1:0] value);
			case (addr)
				ADDR_MIN_SUM: min_sum = value[MIN_SUM_BITS-1:0];
				ADDR_WEIGHT:  weight  = value[WEIGHT_BITS-1:0];
				default: ;
			endcase
		endfunction

		function longint trimmed_mean(int c);
			longint t;
			t = longint'(chan_sum[c]) - longint'(chan_max[c]) - longint'(chan_min[c]);
			if (t < 0)
				t = 0;
			return t / (SAMPLES_PER_CHANNEL - 2);
		endfunction

		function longint q15_ratio(longint diff, longint total);
			longint mag;
			longint q;
			mag = (diff < 0) ? -diff : diff;
			q   = (mag * Q_ONE) / total;
			return (diff < 0) ? -q : q;
		endfunction

		function longint clamp16(longint v);
			if (v > 32767)
				return 32767;
			if (v < -32768)
				return -32768;
			return v;
		endfunction

		function void note_sample(item_t it);
			longint  m [CHANNELS];
			longint  nxt;
			longint  hsum;
			longint  vsum;
			longint  h;
			longint  v;
			longint  w;
			longint  pos;
			result_t res;
			nxt = longint'(chan_sum[it.channel]) + longint'(it.sample);
			if (nxt > (1 << SUM_BITS) - 1)
				nxt = (1 << SUM_BITS) - 1;
			chan_sum[it.channel] = nxt[SUM_BITS-1:0];
			if (it.sample > chan_max[it.channel])
				chan_max[it.channel] = it.sample;
			if (it.sample < chan_min[it.channel])
				chan_min[it.channel] = it.sample;
			if (!it.frame_end)
				return;
			for (int c = 0; c < CHANNELS; c++)
				m[c] = trimmed_mean(c);
			clear_frame();
			hsum = m[1] + m[2];
			vsum = m[0] + m[3];
			if (hsum == 0 || hsum < longint'(min_sum)) begin
				pos      = 0;
				res.path = PATH_NONE;
			end else begin
				h = q15_ratio(m[1] - m[2], hsum);
				if (vsum == 0 || vsum < longint'(min_sum)) begin
					pos      = clamp16(h);
					res.path = PATH_HORIZ;
				end else begin
					w        = (longint'(weight) > Q_ONE) ? Q_ONE : longint'(weight);
					v        = q15_ratio(m[0] - m[3], vsum);
					pos      = clamp16((h * (Q_ONE - w) + v * w) / Q_ONE);
					res.path = PATH_BLEND;
				end
			end
			res.position = pos[POS_BITS-1:0];
			pending.push_back(res);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$error("result transaction with nothing expected: position %0d path %0d",
					got.position, got.path);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.position !== want.position) begin
				$error("position: expected %0d, actual %0d", want.position, got.position);
				errors++;
			end
			if (got.path !== want.path) begin
				$error("path: expected %0d, actual %0d", want.path, got.path);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	item_t                item;
	logic                 done;
	result_t              result;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	position_scoreboard sb;
	item_t              frame_q [$];
	int                 items_sent;
	bit                 no_gaps;
	int                 idle_cycles;

	inductor_position_ratio_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_sample(item);
			if (done)
				sb.check_result(result);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (psel && penable && pready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample(int mode, int base);
		int v;
		case (mode)
			MODE_UNIFORM: v = $urandom_range(0, 4095);
			MODE_NEAR: begin
				v = base + int'($urandom_range(0, 31)) - 16;
				if (v < 0)
					v = 0;
				if (v > 4095)
					v = 4095;
			end
			MODE_EXTREME: v = $urandom_range(0, 1) ? 4095 : 0;
			default: v = 0;
		endcase
		return v[SAMPLE_BITS-1:0];
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		item  <= it;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic add_samples(input int ch, input int value, input int count);
		item_t it;
		for (int i = 0; i < count; i++) begin
			it.sample    = value[SAMPLE_BITS-1:0];
			it.channel   = ch[CHANNEL_BITS-1:0];
			it.frame_end = 1'b0;
			frame_q.push_back(it);
		end
	endtask

	task automatic send_frame();
		frame_q[frame_q.size() - 1].frame_end = 1'b1;
		foreach (frame_q[i])
			send_item(frame_q[i]);
		frame_q.delete();
	endtask

	task automatic random_frame();
		int    mode;
		int    base;
		int    cnt;
		int    r;
		int    j;
		item_t tmp;
		no_gaps = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 99) < 80) begin
			for (int c = 0; c < CHANNELS; c++) begin
				r    = $urandom_range(0, 9);
				mode = (r < 4) ? MODE_UNIFORM : (r < 7) ? MODE_NEAR :
					(r < 9) ? MODE_EXTREME : MODE_ZERO;
				base = $urandom_range(0, 4095);
				for (int k = 0; k < SAMPLES_PER_CHANNEL; k++)
					add_samples(c, int'(pick_sample(mode, base)), 1);
			end
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				cnt  = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) :
					$urandom_range(0, 6);
				mode = $urandom_range(MODE_UNIFORM, MODE_ZERO);
				base = $urandom_range(0, 4095);
				for (int k = 0; k < cnt; k++)
					add_samples(c, int'(pick_sample(mode, base)), 1);
			end
			if (frame_q.size() == 0)
				add_samples($urandom_range(0, 3), $urandom_range(0, 4095), 1);
		end
		for (int i = frame_q.size() - 1; i > 0; i--) begin
			j          = $urandom_range(0, i);
			tmp        = frame_q[i];
			frame_q[i] = frame_q[j];
			frame_q[j] = tmp;
		end
		send_frame();
	endtask

	task automatic random_phase(input int count);
		int target;
		target = items_sent + count;
		while (items_sent < target)
			random_frame();
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] value);
		logic [DATA_BITS-1:0] mask;
		mask    = (addr == ADDR_MIN_SUM) ? DATA_BITS'((1 << MIN_SUM_BITS) - 1) :
			DATA_BITS'((1 << WEIGHT_BITS) - 1);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_register(addr, value);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if ((prdata & mask) !== (value & mask)) begin
			$error("register %0d readback: expected %0d, actual %0d", addr, value & mask,
				prdata & mask);
			sb.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [MIN_SUM_BITS-1:0] min_sums [6];
		logic [WEIGHT_BITS-1:0]  weights [6];
		sb          = new();
		items_sent  = 0;
		no_gaps     = 1'b0;
		idle_cycles = 0;
		min_sums    = '{13'd0, 13'd8191, 13'd1, 13'd0, 13'd50, 13'd100};
		weights     = '{16'd0, 16'd32768, 16'd65535, 16'd0, 16'd32768, 16'd16384};
		min_sums[3] = MIN_SUM_BITS'($urandom_range(0, 400));
		weights[3]  = WEIGHT_BITS'($urandom_range(0, 65535));
		arst_n  <= 1'b0;
		start   <= 1'b0;
		item    <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A single sample leaves every trimmed mean at zero.
		add_samples(0, 4095, 1);
		send_frame();
		// Channel 1 overflows its sum; channel 2 sits at full scale.
		add_samples(1, 4095, 10);
		add_samples(2, 4095, 3);
		send_frame();
		// Full-scale opposite ratios on both pairs, so the blend applies.
		add_samples(1, 0, 3);
		add_samples(2, 4095, 3);
		add_samples(0, 4095, 3);
		add_samples(3, 0, 3);
		send_frame();

		random_phase(PHASE_ITEMS);
		for (int p = 0; p < 6; p++) begin
			wait_idle();
			cfg_write(ADDR_MIN_SUM, DATA_BITS'(min_sums[p]));
			cfg_write(ADDR_WEIGHT, DATA_BITS'(weights[p]));
			random_phase(PHASE_ITEMS);
		end

		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
